@@ design/hpcs_pkg.sv @@
// ---------------------------------------------------------------------------
// hpcs_pkg
// Shared types and the fp32-to-fp16 narrowing function of the converter.
// ---------------------------------------------------------------------------
`default_nettype none

package hpcs_pkg;

    localparam logic [15:0] HALF_INF_BITS  = 16'h7c00;
    localparam logic [15:0] HALF_QUIET_BIT = 16'h0200;
    localparam logic [23:0] ROUND_ADD      = 24'h002000;
    localparam logic [7:0]  FP32_EXP_MAX   = 8'hff;
    localparam logic [9:0]  EXP_REBIAS     = 10'd112;
    localparam logic [31:0] FP32_INF_BITS  = 32'h7f800000;

    // register indexes, decoded from paddr[2]
    localparam logic REG_SCALE_FACTOR = 1'b0;
    localparam logic REG_SCALE_ENABLE = 1'b1;

    // scale factor kept in normalized form
    typedef struct packed {
        logic              sign;
        logic [23:0]       mant;
        logic signed [9:0] exp;
        logic              is_zero;
        logic              is_inf;
        logic              is_nan;
    } hpcs_factor_t;

    // result of the multiply pipeline
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        bypass;
        logic [15:0] half;
        logic        nan;
        logic [31:0] prod;
    } hpcs_prod_t;

    // fp32 bits to fp16 bits; first dropped bit rounds up
    function automatic logic [15:0] narrow_to_half(input logic [31:0] f);
        logic              sign;
        logic [22:0]       mant;
        logic [7:0]        efield;
        logic signed [9:0] exp;
        logic [3:0]        sh;
        logic [23:0]       m;
        logic [15:0]       res;
        sign   = f[31];
        mant   = f[22:0];
        efield = f[30:23];
        exp    = $signed({2'b00, efield}) - $signed(EXP_REBIAS);
        sh     = 4'd0;
        m      = 24'd0;
        if (efield == FP32_EXP_MAX) begin
            res = {sign, 15'd0} | HALF_INF_BITS | ((mant != 23'd0) ? HALF_QUIET_BIT : 16'd0);
        end else if (exp >= 10'sd31) begin
            res = {sign, 15'd0} | HALF_INF_BITS;
        end else if (exp <= 10'sd0) begin
            if (exp < -10'sd10) begin
                res = {sign, 15'd0};
            end else begin
                sh = 4'(10'sd1 - exp);
                m  = {1'b1, mant} >> sh;
                if (m[12]) begin
                    m = m + ROUND_ADD;
                end
                res = {sign, 4'd0, m[23:13]};
            end
        end else begin
            m = {1'b0, mant};
            if (m[12]) begin
                m = m + ROUND_ADD;
                if (m[23]) begin
                    m   = 24'd0;
                    exp = exp + 10'sd1;
                end
            end
            if (exp >= 10'sd31) begin
                res = {sign, 15'd0} | HALF_INF_BITS;
            end else begin
                res = {sign, exp[4:0], m[22:13]};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/hpcs_scale_mul.sv @@
// ---------------------------------------------------------------------------
// hpcs_scale_mul
// Two-stage fp32 multiply of a flushed fp16 value by the scale factor,
// round-to-nearest-even, giving fp32 product bits.
// ---------------------------------------------------------------------------
`default_nettype none

module hpcs_scale_mul (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 valid,
    input  wire logic                 last,
    input  wire logic                 bypass,
    input  wire logic [15:0]          half,
    input  wire hpcs_pkg::hpcs_factor_t factor,
    output hpcs_pkg::hpcs_prod_t      result
);
    import hpcs_pkg::*;

    // stage A: classify and multiply
    logic              a_valid_reg;
    logic              a_last_reg;
    logic              a_bypass_reg;
    logic [15:0]       a_half_reg;
    logic              a_sign_reg;
    logic              a_nan_reg;
    logic              a_inf_reg;
    logic              a_zero_reg;
    logic signed [9:0] a_exp_reg;
    logic [34:0]       a_prod_reg;

    logic [4:0] xe;
    logic [9:0] xm;
    logic       x_zero;
    logic       x_inf;
    logic       x_nan;
    logic       nan_next;

    assign xe       = half[14:10];
    assign xm       = half[9:0];
    assign x_zero   = (xe == 5'd0);
    assign x_inf    = (xe == 5'h1f) && (xm == 10'd0);
    assign x_nan    = (xe == 5'h1f) && (xm != 10'd0);
    assign nan_next = x_nan || factor.is_nan || (x_inf && factor.is_zero)
                   || (x_zero && factor.is_inf);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_last_reg   <= last;
        a_bypass_reg <= bypass;
        a_half_reg   <= half;
        a_sign_reg   <= half[15] ^ factor.sign;
        a_nan_reg    <= nan_next;
        a_inf_reg    <= (x_inf || factor.is_inf) && !nan_next;
        a_zero_reg   <= (x_zero || factor.is_zero) && !nan_next;
        a_exp_reg    <= $signed({5'd0, xe}) + factor.exp - 10'sd15;
        a_prod_reg   <= 35'({1'b1, xm}) * 35'(factor.mant);
    end

    // stage B: normalize, round, pack
    logic              b_hi;
    logic [22:0]       b_m23;
    logic              b_guard;
    logic              b_sticky;
    logic              b_up;
    logic [24:0]       b_m25;
    logic signed [9:0] b_exp;
    logic [22:0]       b_mant;
    logic [31:0]       prod_next;

    always_comb
    begin
        b_hi = a_prod_reg[34];
        if (b_hi)
        begin
            b_m23    = a_prod_reg[33:11];
            b_guard  = a_prod_reg[10];
            b_sticky = |a_prod_reg[9:0];
        end
        else
        begin
            b_m23    = a_prod_reg[32:10];
            b_guard  = a_prod_reg[9];
            b_sticky = |a_prod_reg[8:0];
        end
        b_up  = b_guard && (b_sticky || b_m23[0]);
        b_m25 = {2'b01, b_m23} + 25'(b_up);
        b_exp = a_exp_reg + $signed({9'd0, b_hi});
        if (b_m25[24])
        begin
            b_exp  = b_exp + 10'sd1;
            b_mant = 23'd0;
        end
        else
        begin
            b_mant = b_m25[22:0];
        end
        if (a_inf_reg || (b_exp >= 10'sd255))
        begin
            prod_next = {a_sign_reg, 31'd0} | FP32_INF_BITS;
        end
        else if (a_zero_reg || (b_exp <= 10'sd0))
        begin
            prod_next = {a_sign_reg, 31'd0};
        end
        else
        begin
            prod_next = {a_sign_reg, b_exp[7:0], b_mant};
        end
    end

    logic        b_valid_reg;
    logic        b_last_reg;
    logic        b_bypass_reg;
    logic [15:0] b_half_reg;
    logic        b_nan_reg;
    logic [31:0] b_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_last_reg   <= a_last_reg;
        b_bypass_reg <= a_bypass_reg;
        b_half_reg   <= a_half_reg;
        b_nan_reg    <= a_nan_reg;
        b_prod_reg   <= prod_next;
    end

    assign result = '{valid: b_valid_reg, last: b_last_reg, bypass: b_bypass_reg,
                      half: b_half_reg, nan: b_nan_reg, prod: b_prod_reg};

`ifndef SYNTH
    // stage A valid follows the input valid in the next cycle
    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> a_valid_reg)
        else $error("stage A lost a transaction");
    // special classes exclude each other
    a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> $onehot0({a_nan_reg, a_inf_reg, a_zero_reg}))
        else $error("conflicting special classes");
    // the nan flag of a stage A transaction carries into stage B
    b_nan_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_nan_reg) |=> (b_valid_reg && b_nan_reg))
        else $error("nan flag dropped");
`endif

endmodule

`default_nettype wire

@@ design/half_precision_convert_and_scale.sv @@
// ---------------------------------------------------------------------------
// half_precision_convert_and_scale
// Converts bf16 or fp16 weight words to fp16, optionally scaling by an fp32
// factor.
// ---------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  input     | start (busy never set) | word_in, source_is_bf16, last_in
//  result    | done strobe, 1 cycle   | half_out, last_out
//  config    | APB write, pready = 1  | paddr, pwdata (0: factor, 4: enable)
//
//  One transaction per cycle; each result passes the stages below in order.
//  Stages: bf16 narrowing, classify + 11x24 multiply, round/pack, narrowing.
//  Reset clears the valid bits and sets the factor to 1.0, scaling off.
//  The result side cannot stall, so busy stays low.
// ---------------------------------------------------------------------------
`default_nettype none

module half_precision_convert_and_scale (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] word_in,
    input  wire logic        source_is_bf16,
    input  wire logic        last_in,
    output logic             done,
    output logic [15:0]      half_out,
    output logic             last_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hpcs_pkg::*;

    // configuration registers
    logic         scale_factor_reg;
    logic [31:0]  factor_bits_reg;
    logic         scale_enable_reg;
    hpcs_factor_t factor_reg;
    hpcs_factor_t factor_next;
    logic         cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;

    // normalize the written factor so the multiplier sees a hidden bit
    logic [4:0] lead_pos;
    logic [4:0] norm_shift;

    always_comb
    begin
        lead_pos = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (pwdata[i])
            begin
                lead_pos = 5'(i);
            end
        end
        norm_shift          = 5'd23 - lead_pos;
        factor_next.sign    = pwdata[31];
        factor_next.is_nan  = (pwdata[30:23] == FP32_EXP_MAX) && (pwdata[22:0] != 23'd0);
        factor_next.is_inf  = (pwdata[30:23] == FP32_EXP_MAX) && (pwdata[22:0] == 23'd0);
        factor_next.is_zero = (pwdata[30:23] == 8'd0) && (pwdata[22:0] == 23'd0);
        if (pwdata[30:23] == 8'd0)
        begin
            factor_next.mant = {1'b0, pwdata[22:0]} << norm_shift;
            factor_next.exp  = 10'sd1 - $signed({5'd0, norm_shift});
        end
        else
        begin
            factor_next.mant = {1'b1, pwdata[22:0]};
            factor_next.exp  = $signed({2'b00, pwdata[30:23]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_bits_reg <= 32'h3f800000;
            factor_reg      <= '{sign: 1'b0, mant: 24'h800000, exp: 10'sd127,
                                 is_zero: 1'b0, is_inf: 1'b0, is_nan: 1'b0};
            scale_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SCALE_FACTOR)
            begin
                factor_bits_reg <= pwdata;
                factor_reg      <= factor_next;
            end
            else
            begin
                scale_enable_reg <= pwdata[0];
            end
        end
    end

    assign scale_factor_reg = factor_bits_reg[31];
    assign prdata = (paddr[2] == REG_SCALE_ENABLE) ? {31'd0, scale_enable_reg}
                                                   : {scale_factor_reg, factor_bits_reg[30:0]};

    // stage 1: bf16 narrowing
    logic        s1_valid_reg;
    logic        s1_last_reg;
    logic        s1_bypass_reg;
    logic [15:0] s1_half_reg;
    logic        accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg   <= last_in;
        s1_bypass_reg <= !scale_enable_reg;
        s1_half_reg   <= source_is_bf16 ? narrow_to_half({word_in, 16'd0}) : word_in;
    end

    // stages 2 and 3: scale multiply
    hpcs_prod_t mul_res;

    hpcs_scale_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (s1_valid_reg),
        .last   (s1_last_reg),
        .bypass (s1_bypass_reg),
        .half   (s1_half_reg),
        .factor (factor_reg),
        .result (mul_res)
    );

    // stage 4: narrow the product, or pass the unscaled value through, and register the result
    logic        done_reg;
    logic        last_out_reg;
    logic [15:0] half_out_reg;
    logic [15:0] half_next;

    always_comb
    begin
        priority if (mul_res.bypass)
        begin
            half_next = mul_res.half;
        end
        else if (mul_res.nan)
        begin
            half_next = {mul_res.prod[31], 15'd0} | HALF_INF_BITS | HALF_QUIET_BIT;
        end
        else
        begin
            half_next = narrow_to_half(mul_res.prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mul_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        last_out_reg <= mul_res.last;
        half_out_reg <= half_next;
    end

    assign done     = done_reg;
    assign half_out = half_out_reg;
    assign last_out = last_out_reg;

`ifndef SYNTH
    // every accepted transaction yields a result
    done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("result missing after accept");
    // no result without an earlier accepted transaction
    done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("spurious result");
    // nan products come out as quiet nan
    nan_output: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_res.valid && !mul_res.bypass && mul_res.nan) |=> (half_out[14:0] == 15'h7e00))
        else $error("nan product not quieted");
`endif

endmodule

`default_nettype wire
